### rtl/core/fdc_pkg.sv
// Package for the fan duty controller: register map, reset values, widths,
// the job record passed between front and back, and the state encodings.
// Used by every file in rtl/core.
package fdc_pkg;

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int TEMP_W      = 12;
	localparam int PCT_W       = 7;
	localparam int POLLS_W     = 8;
	localparam int DUTY_W      = 16;
	localparam int NUM_W       = 19;
	localparam int PROD_W      = NUM_W + DUTY_W;
	localparam int STEP_CNT_W  = $clog2(PROD_W);
	localparam int QUEUE_DEPTH = 2;
	localparam int PCT_SCALE   = 100;

	localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_MID  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PCT_LOW   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PCT_MID   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PCT_HIGH  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX  = 3'd7;

	localparam logic signed [TEMP_W-1:0] RST_TEMP_LOW  = 12'sd400;
	localparam logic signed [TEMP_W-1:0] RST_TEMP_MID  = 12'sd432;
	localparam logic signed [TEMP_W-1:0] RST_TEMP_HIGH = 12'sd480;
	localparam logic [PCT_W-1:0]         RST_PCT_LOW   = 7'd30;
	localparam logic [PCT_W-1:0]         RST_PCT_MID   = 7'd50;
	localparam logic [PCT_W-1:0]         RST_PCT_HIGH  = 7'd100;
	localparam logic [POLLS_W-1:0]       RST_DEBOUNCE  = 8'd4;
	localparam logic [DUTY_W-1:0]        RST_DUTY_MAX  = 16'd999;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp_low;
		logic signed [TEMP_W-1:0] temp_mid;
		logic signed [TEMP_W-1:0] temp_high;
		logic [PCT_W-1:0]         pct_low;
		logic [PCT_W-1:0]         pct_mid;
		logic [PCT_W-1:0]         pct_high;
		logic [POLLS_W-1:0]       debounce_polls;
		logic [DUTY_W-1:0]        duty_max;
	} fdc_cfg_t;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [NUM_W-1:0] den;
		logic             manual;
	} fdc_job_t;

	typedef enum logic [1:0] {PH_IDLE, PH_PRESSED, PH_HOLD} fdc_phase_t;

	typedef enum logic [2:0] {KIND_ZERO, KIND_FULL, KIND_FLAT, KIND_RAMP, KIND_POT} fdc_kind_t;

	typedef enum logic [1:0] {BK_IDLE, BK_MUL, BK_DIV, BK_WAIT} fdc_back_state_t;

endpackage

### rtl/core/fdc_if.sv
// Channel interfaces of the fan duty controller: request, result and
// configuration write. Widths come from fdc_pkg, the pot sample width from ADC_BITS.
interface fdc_in_if #(parameter int ADC_BITS = 12);
	logic                                valid;
	logic                                ready;
	logic                                req_type;
	logic                                button_level;
	logic [ADC_BITS-1:0]                 pot_sample;
	logic signed [fdc_pkg::TEMP_W-1:0]   temperature;

	modport source (output valid, req_type, button_level, pot_sample, temperature,
		input ready);
	modport sink (input valid, req_type, button_level, pot_sample, temperature,
		output ready);
endinterface

interface fdc_out_if;
	logic                         valid;
	logic                         ready;
	logic [fdc_pkg::DUTY_W-1:0]   duty;
	logic                         manual_active;

	modport source (output valid, duty, manual_active, input ready);
	modport sink (input valid, duty, manual_active, output ready);
endinterface

interface fdc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [fdc_pkg::CFG_IDX_W-1:0]    index;
	logic [fdc_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/fdc_front.sv
// Front end: accepts request beats, runs the button debounce, picks the curve
// segment and turns each item that yields a result into a numerator/denominator
// job for the back end. Depends on fdc_pkg and fdc_if.
module fdc_front #(
	parameter int ADC_BITS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	fdc_in_if.sink            req,
	input  fdc_pkg::fdc_cfg_t cfg_regs,
	output fdc_pkg::fdc_job_t push_job,
	output logic              push_valid,
	input  logic              push_ready
);
	import fdc_pkg::*;

	localparam logic [NUM_W-1:0] POT_FULL = NUM_W'((1 << ADC_BITS) - 1);

	fdc_phase_t         phase_q, phase_n;
	logic [POLLS_W-1:0] polls_q, polls_n, polls_inc;
	logic               manual_q, manual_n;

	logic                      accept;
	logic signed [TEMP_W-1:0]  t_in;
	logic signed [TEMP_W:0]    t_ext, t0, t1, r_full, d_full;
	logic [PCT_W-1:0]          pa, pb;
	fdc_kind_t                 kind;
	logic                      emit;

	logic                valid_s1;
	fdc_kind_t           kind_s1;
	logic [TEMP_W-1:0]   r_s1, d_s1;
	logic [PCT_W-1:0]    pa_s1, pb_s1;
	logic [ADC_BITS-1:0] pot_s1;

	assign accept    = req.valid && req.ready;
	assign req.ready = !valid_s1 || push_ready;
	assign t_in      = $signed(req.temperature);

	always_comb begin
		phase_n   = phase_q;
		polls_n   = polls_q;
		manual_n  = manual_q;
		polls_inc = (polls_q == '1) ? polls_q : polls_q + POLLS_W'(1);
		case (phase_q)
			PH_PRESSED: begin
				if (req.button_level) begin
					phase_n = PH_IDLE;
				end else begin
					polls_n = polls_inc;
					if (polls_inc >= cfg_regs.debounce_polls) begin
						manual_n = !manual_q;
						phase_n  = PH_HOLD;
					end
				end
			end
			PH_HOLD: begin
				if (req.button_level) begin
					phase_n = PH_IDLE;
				end
			end
			default: begin
				phase_n = PH_IDLE;
				if (!req.button_level) begin
					phase_n = PH_PRESSED;
					polls_n = '0;
				end
			end
		endcase
	end

	always_comb begin
		t_ext = (TEMP_W+1)'(t_in);
		if (t_in <= $signed(cfg_regs.temp_mid)) begin
			t0 = (TEMP_W+1)'($signed(cfg_regs.temp_low));
			t1 = (TEMP_W+1)'($signed(cfg_regs.temp_mid));
			pa = cfg_regs.pct_low;
			pb = cfg_regs.pct_mid;
		end else begin
			t0 = (TEMP_W+1)'($signed(cfg_regs.temp_mid));
			t1 = (TEMP_W+1)'($signed(cfg_regs.temp_high));
			pa = cfg_regs.pct_mid;
			pb = cfg_regs.pct_high;
		end
		r_full = t1 - t0;
		d_full = t_ext - t0;
		if (!req.req_type) begin
			kind = KIND_POT;
		end else if (t_in < $signed(cfg_regs.temp_low)) begin
			kind = KIND_ZERO;
		end else if (t_in >= $signed(cfg_regs.temp_high)) begin
			kind = KIND_FULL;
		end else if (r_full <= 0) begin
			kind = KIND_FLAT;
		end else begin
			kind = KIND_RAMP;
		end
		emit = req.req_type ? !manual_q : manual_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			polls_q  <= '0;
			manual_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept && !req.req_type) begin
				phase_q  <= phase_n;
				polls_q  <= polls_n;
				manual_q <= manual_n;
			end
			if (req.ready) begin
				valid_s1 <= accept && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			r_s1    <= r_full[TEMP_W-1:0];
			d_s1    <= d_full[TEMP_W-1:0];
			pa_s1   <= pa;
			pb_s1   <= pb;
			pot_s1  <= req.pot_sample;
		end
	end

	assign push_valid = valid_s1;

	always_comb begin
		push_job.manual = (kind_s1 == KIND_POT);
		case (kind_s1)
			KIND_FULL: begin
				push_job.num = NUM_W'(1);
				push_job.den = NUM_W'(1);
			end
			KIND_FLAT: begin
				push_job.num = NUM_W'(pb_s1);
				push_job.den = NUM_W'(PCT_SCALE);
			end
			KIND_RAMP: begin
				push_job.num = NUM_W'(pa_s1) * NUM_W'(r_s1 - d_s1)
					+ NUM_W'(pb_s1) * NUM_W'(d_s1);
				push_job.den = NUM_W'(r_s1) * NUM_W'(PCT_SCALE);
			end
			KIND_POT: begin
				push_job.num = NUM_W'(pot_s1);
				push_job.den = POT_FULL;
			end
			default: begin
				push_job.num = '0;
				push_job.den = NUM_W'(1);
			end
		endcase
	end

endmodule

### rtl/core/fdc_queue.sv
// Two-entry job queue between the front end and the back end.
// Depends on fdc_pkg.
module fdc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  fdc_pkg::fdc_job_t push_job,
	input  logic              push_valid,
	output logic              push_ready,
	output fdc_pkg::fdc_job_t pop_job,
	output logic              pop_valid,
	input  logic              pop_ready
);
	import fdc_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	fdc_job_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

### rtl/core/fdc_back.sv
// Back end: multiplies a job's numerator by duty_max, divides bit-serially by
// its denominator, clamps to duty_max and holds the result in the output register.
// Depends on fdc_pkg and fdc_if.
module fdc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fdc_pkg::fdc_job_t           pop_job,
	input  logic                        pop_valid,
	output logic                        pop_ready,
	input  logic [fdc_pkg::DUTY_W-1:0]  duty_max,
	fdc_out_if.source                   rsp
);
	import fdc_pkg::*;

	fdc_back_state_t       state_q, state_n;
	fdc_job_t              job_q;
	logic [PROD_W-1:0]     dvd_q;
	logic [NUM_W-1:0]      rem_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic                  out_valid_q, out_manual_q;
	logic [DUTY_W-1:0]     out_duty_q, duty_clamped;

	logic [NUM_W:0] rem_sh, rem_nx;
	logic           ge, last_step, out_free, load_out;

	assign rem_sh    = {rem_q, dvd_q[PROD_W-1]};
	assign ge        = (rem_sh >= {1'b0, job_q.den});
	assign rem_nx    = ge ? rem_sh - {1'b0, job_q.den} : rem_sh;
	assign last_step = (cnt_q == STEP_CNT_W'(PROD_W - 1));
	assign out_free  = !out_valid_q || rsp.ready;
	assign duty_clamped = (dvd_q > PROD_W'(duty_max)) ? duty_max : dvd_q[DUTY_W-1:0];

	always_comb begin
		state_n   = state_q;
		pop_ready = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					state_n = BK_MUL;
				end
			end
			BK_MUL: begin
				state_n = BK_DIV;
			end
			BK_DIV: begin
				if (last_step) begin
					state_n = BK_WAIT;
				end
			end
			BK_WAIT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_n  = BK_IDLE;
				end
			end
			default: begin
				state_n = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			job_q <= pop_job;
		end
		if (state_q == BK_MUL) begin
			dvd_q <= PROD_W'(job_q.num) * PROD_W'(duty_max);
			rem_q <= '0;
			cnt_q <= '0;
		end else if (state_q == BK_DIV) begin
			dvd_q <= {dvd_q[PROD_W-2:0], ge};
			rem_q <= rem_nx[NUM_W-1:0];
			cnt_q <= cnt_q + STEP_CNT_W'(1);
		end
		if (load_out) begin
			out_duty_q   <= duty_clamped;
			out_manual_q <= job_q.manual;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.duty          = out_duty_q;
	assign rsp.manual_active = out_manual_q;

endmodule

### rtl/core/fan_duty_controller.sv
// Fan duty controller top level: configuration registers, front end, job queue
// and back end. Depends on fdc_pkg, fdc_if, fdc_front, fdc_queue and fdc_back.
//
// The req channel takes one beat per item: a poll (req_type 0) with the button
// level and a potentiometer code, or a temperature sample (req_type 1). The rsp
// channel returns at most one beat per item, in order: a duty value and whether
// it came from manual mode. The cfg channel writes one register per beat and is
// always ready; write it only while the block is idle.
// An item that yields no result is absorbed by the front stage. An item that
// yields a result passes through the front stage and the two-entry queue, then
// the back end loads it, multiplies it by duty_max, runs the restoring divider
// that produces one quotient bit per cycle for all 35 quotient bits, and loads
// the output register. The back end takes no new job until that load is done,
// so the divider limits the sustained rate of results. Reset restores the default
// registers, auto mode, the idle button phase and empty queue and output. When
// rsp stalls, the output register holds its beat, the back end waits, the queue
// fills and then req deasserts ready.
module fan_duty_controller #(
	parameter int ADC_BITS = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	fdc_in_if.sink     req,
	fdc_out_if.source  rsp,
	fdc_cfg_if.sink    cfg
);
	import fdc_pkg::*;

	fdc_cfg_t cfg_q;
	fdc_job_t push_job, pop_job;
	logic     push_valid, push_ready, pop_valid, pop_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_low       <= RST_TEMP_LOW;
			cfg_q.temp_mid       <= RST_TEMP_MID;
			cfg_q.temp_high      <= RST_TEMP_HIGH;
			cfg_q.pct_low        <= RST_PCT_LOW;
			cfg_q.pct_mid        <= RST_PCT_MID;
			cfg_q.pct_high       <= RST_PCT_HIGH;
			cfg_q.debounce_polls <= RST_DEBOUNCE;
			cfg_q.duty_max       <= RST_DUTY_MAX;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TEMP_LOW:  cfg_q.temp_low       <= cfg.data[TEMP_W-1:0];
				REG_TEMP_MID:  cfg_q.temp_mid       <= cfg.data[TEMP_W-1:0];
				REG_TEMP_HIGH: cfg_q.temp_high      <= cfg.data[TEMP_W-1:0];
				REG_PCT_LOW:   cfg_q.pct_low        <= cfg.data[PCT_W-1:0];
				REG_PCT_MID:   cfg_q.pct_mid        <= cfg.data[PCT_W-1:0];
				REG_PCT_HIGH:  cfg_q.pct_high       <= cfg.data[PCT_W-1:0];
				REG_DEBOUNCE:  cfg_q.debounce_polls <= cfg.data[POLLS_W-1:0];
				REG_DUTY_MAX:  cfg_q.duty_max       <= cfg.data[DUTY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	fdc_front #(
		.ADC_BITS (ADC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg_regs   (cfg_q),
		.push_job   (push_job),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	fdc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_job   (push_job),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_job    (pop_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	fdc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_job   (pop_job),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.duty_max  (cfg_q.duty_max),
		.rsp       (rsp)
	);

	a_duty_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.duty <= cfg_q.duty_max)
		else $error("duty above duty_max");

	a_back_one_job: assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid && pop_ready |=> !pop_ready)
		else $error("back end took a second job while busy");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!push_ready |-> pop_valid)
		else $error("queue full and empty at once");

endmodule

### test/fdc_tb_pkg.sv
// Testbench codes for the fan duty controller: the request kinds on the req channel.
// Shared by the duty checker and the testbench top. No other dependencies.
`timescale 1ns / 1ps

package fdc_tb_pkg;

	localparam logic REQ_POLL = 1'b0;
	localparam logic REQ_TEMP = 1'b1;

endpackage

### test/fdc_duty_checker.sv
// Duty checker for the fan duty controller: watches req, rsp and cfg beats.
// It tracks registers and debounce state, predicts each duty and compares in order.
// Depends on fdc_pkg, fdc_tb_pkg and the channel interfaces in fdc_if.
`timescale 1ns / 1ps

module fdc_duty_checker #(
	parameter int ADC_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	fdc_in_if    req,
	fdc_out_if   rsp,
	fdc_cfg_if   cfg,
	output int   errors,
	output int   pending,
	output int   results,
	output int   manual_results
);
	import fdc_pkg::*;
	import fdc_tb_pkg::*;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              manual;
	} duty_beat_t;

	localparam longint POT_FULL = (longint'(1) << ADC_BITS) - 1;

	logic signed [TEMP_W-1:0] ramp_lo, ramp_knee, ramp_hi;
	logic [PCT_W-1:0]         pct_lo, pct_knee, pct_hi;
	logic [POLLS_W-1:0]       polls_needed;
	logic [DUTY_W-1:0]        duty_full;
	fdc_phase_t               btn_phase;
	logic [POLLS_W-1:0]       held_polls;
	logic                     manual_on;
	duty_beat_t               duty_queue[$];

	function automatic logic [DUTY_W-1:0] clamp_duty(longint v);
		return (v > longint'(duty_full)) ? duty_full : DUTY_W'(v);
	endfunction

	function automatic logic [DUTY_W-1:0] segment_duty(longint t, longint t0, longint t1,
		longint pa, longint pb);
		longint span, off, mix, full;
		full = longint'(duty_full);
		span = t1 - t0;
		off = t - t0;
		if (span <= 0)
			return clamp_duty(pb * full / PCT_SCALE);
		if (off < 0)
			off = 0;
		if (off > span)
			off = span;
		mix = pa * (span - off) + pb * off;
		return clamp_duty(mix * full / (PCT_SCALE * span));
	endfunction

	function automatic void flag_mismatch(string why);
		errors++;
		if (errors <= 10)
			$display("MISMATCH at %0t: %s", $realtime, why);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		duty_beat_t         seen, want;
		longint             t_in;
		logic [DUTY_W-1:0]  curve;
		if (!arst_n) begin
			ramp_lo = RST_TEMP_LOW;
			ramp_knee = RST_TEMP_MID;
			ramp_hi = RST_TEMP_HIGH;
			pct_lo = RST_PCT_LOW;
			pct_knee = RST_PCT_MID;
			pct_hi = RST_PCT_HIGH;
			polls_needed = RST_DEBOUNCE;
			duty_full = RST_DUTY_MAX;
			btn_phase = PH_IDLE;
			held_polls = '0;
			manual_on = 1'b0;
			duty_queue.delete();
			errors = 0;
			results = 0;
			manual_results = 0;
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				REG_TEMP_LOW:  ramp_lo = cfg.data[TEMP_W-1:0];
				REG_TEMP_MID:  ramp_knee = cfg.data[TEMP_W-1:0];
				REG_TEMP_HIGH: ramp_hi = cfg.data[TEMP_W-1:0];
				REG_PCT_LOW:   pct_lo = cfg.data[PCT_W-1:0];
				REG_PCT_MID:   pct_knee = cfg.data[PCT_W-1:0];
				REG_PCT_HIGH:  pct_hi = cfg.data[PCT_W-1:0];
				REG_DEBOUNCE:  polls_needed = cfg.data[POLLS_W-1:0];
				REG_DUTY_MAX:  duty_full = cfg.data[DUTY_W-1:0];
				default: ;
				endcase
			end

			if (rsp.valid && rsp.ready) begin
				seen.duty = rsp.duty;
				seen.manual = rsp.manual_active;
				results++;
				if (seen.manual)
					manual_results++;
				if (duty_queue.size() == 0) begin
					flag_mismatch($sformatf("result beat %0d with none expected: duty %0d manual %0b",
						results, seen.duty, seen.manual));
				end else begin
					want = duty_queue.pop_front();
					if (want.duty !== seen.duty || want.manual !== seen.manual)
						flag_mismatch($sformatf(
							"result beat %0d: expected duty %0d manual %0b, got duty %0d manual %0b",
							results, want.duty, want.manual, seen.duty, seen.manual));
				end
			end

			if (req.valid && req.ready) begin
				if (req.req_type == REQ_POLL) begin
					case (btn_phase)
					PH_PRESSED: begin
						if (req.button_level) begin
							btn_phase = PH_IDLE;
						end else begin
							if (held_polls != '1)
								held_polls++;
							if (held_polls >= polls_needed) begin
								manual_on = !manual_on;
								btn_phase = PH_HOLD;
							end
						end
					end
					PH_HOLD: begin
						if (req.button_level)
							btn_phase = PH_IDLE;
					end
					default: begin
						btn_phase = PH_IDLE;
						if (!req.button_level) begin
							btn_phase = PH_PRESSED;
							held_polls = '0;
						end
					end
					endcase
					if (manual_on) begin
						want.duty = clamp_duty(longint'(req.pot_sample) * longint'(duty_full) / POT_FULL);
						want.manual = 1'b1;
						duty_queue.push_back(want);
					end
				end else if (!manual_on) begin
					t_in = longint'($signed(req.temperature));
					if (t_in < longint'(ramp_lo))
						curve = '0;
					else if (t_in >= longint'(ramp_hi))
						curve = duty_full;
					else if (t_in <= longint'(ramp_knee))
						curve = segment_duty(t_in, ramp_lo, ramp_knee, pct_lo, pct_knee);
					else
						curve = segment_duty(t_in, ramp_knee, ramp_hi, pct_knee, pct_hi);
					want.duty = curve;
					want.manual = 1'b0;
					duty_queue.push_back(want);
				end
			end
			pending <= duty_queue.size();
		end
	end

endmodule

### test/fan_duty_controller_tb.sv
// Testbench top for fan_duty_controller: clock, reset, register settings, request
// stimulus with bursts and gaps, result back-pressure and the verdict.
// Depends on fdc_pkg, fdc_tb_pkg, fdc_if, the RTL and fdc_duty_checker.
`timescale 1ns / 1ps

module fan_duty_controller_tb;
	import fdc_pkg::*;
	import fdc_tb_pkg::*;

	localparam int ADC_BITS       = 12;
	localparam int POT_MAX        = (1 << ADC_BITS) - 1;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 60;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASE_ITEMS    = 110;

	typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_SPARSE, RX_PULSE} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	int errors, pending, results, manual_results;
	int sent_items = 0;
	int sent_polls = 0;
	int sent_temps = 0;
	int settings_used = 1;
	int idle_cycles = 0;
	int burst_left = 0;
	bit hold_rsp = 1'b0;
	rx_mode_t rx_mode;

	logic signed [TEMP_W-1:0] cur_lo = RST_TEMP_LOW;
	logic signed [TEMP_W-1:0] cur_knee = RST_TEMP_MID;
	logic signed [TEMP_W-1:0] cur_hi = RST_TEMP_HIGH;
	logic [POLLS_W-1:0]       cur_polls = RST_DEBOUNCE;

	fdc_in_if #(.ADC_BITS(ADC_BITS)) req_if ();
	fdc_out_if rsp_if ();
	fdc_cfg_if cfg_if ();

	fan_duty_controller #(.ADC_BITS(ADC_BITS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	fdc_duty_checker #(.ADC_BITS(ADC_BITS)) duty_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_if),
		.rsp            (rsp_if),
		.cfg            (cfg_if),
		.errors         (errors),
		.pending        (pending),
		.results        (results),
		.manual_results (manual_results)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
			(cfg_if.valid && cfg_if.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int seg, k;
		rsp_if.ready <= 1'b0;
		@(posedge clk);
		forever begin
			seg = $urandom_range(20, 200);
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			for (k = 0; k < seg; k++) begin
				if (hold_rsp) begin
					hold_rsp = 1'b0;
					rsp_if.ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
				end
				case (rx_mode)
				RX_OPEN:   rsp_if.ready <= 1'b1;
				RX_HALF:   rsp_if.ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: rsp_if.ready <= ($urandom_range(0, 4) == 0);
				default:   rsp_if.ready <= k[3];
				endcase
				@(posedge clk);
			end
		end
	end

	task automatic send_item(input int kind, input int level, input int pot, input int temp);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap != 0) begin
				req_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_if.valid <= 1'b1;
		req_if.req_type <= 1'(kind);
		req_if.button_level <= 1'(level);
		req_if.pot_sample <= ADC_BITS'(pot);
		req_if.temperature <= TEMP_W'(temp);
		do @(posedge clk); while (!req_if.ready);
		if (1'(kind) == REQ_TEMP)
			sent_temps++;
		else
			sent_polls++;
		sent_items++;
	endtask

	task automatic send_poll(input int level, input int pot);
		send_item(REQ_POLL, level, pot, $urandom);
	endtask

	task automatic send_temp(input int temp);
		send_item(REQ_TEMP, $urandom, $urandom, temp);
	endtask

	function automatic int pick_pot();
		case ($urandom_range(0, 3))
		0: return 0;
		1: return POT_MAX;
		default: return $urandom_range(0, POT_MAX);
		endcase
	endfunction

	function automatic int pick_temp();
		int anchor;
		case ($urandom_range(0, 5))
		0: return int'($urandom_range(0, 2640)) - 640;
		1: return int'($urandom_range(0, 4095)) - 2048;
		default: begin
			case ($urandom_range(0, 2))
			0: anchor = cur_lo;
			1: anchor = cur_knee;
			default: anchor = cur_hi;
			endcase
			if ($urandom_range(0, 1) == 0)
				return anchor + int'($urandom_range(0, 4)) - 2;
			return anchor + int'($urandom_range(0, 80)) - 40;
		end
		endcase
	endfunction

	function automatic int rand_pct();
		return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 100);
	endfunction

	function automatic int junk_above(input int v, input int w);
		if ($urandom_range(0, 1) == 0)
			return v;
		return (v & ((1 << w) - 1)) | ((int'($urandom_range(0, 65535)) >> w) << w);
	endfunction

	task automatic wait_idle();
		req_if.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= CFG_DATA_W'(data);
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
		REG_TEMP_LOW:  cur_lo = TEMP_W'(data);
		REG_TEMP_MID:  cur_knee = TEMP_W'(data);
		REG_TEMP_HIGH: cur_hi = TEMP_W'(data);
		REG_DEBOUNCE:  cur_polls = POLLS_W'(data);
		default: ;
		endcase
	endtask

	task automatic load_regs(input int tl, input int tm, input int th, input int pl,
		input int pm, input int ph, input int polls, input int dmax);
		wait_idle();
		write_reg(REG_TEMP_LOW, tl);
		write_reg(REG_TEMP_MID, tm);
		write_reg(REG_TEMP_HIGH, th);
		write_reg(REG_PCT_LOW, pl);
		write_reg(REG_PCT_MID, pm);
		write_reg(REG_PCT_HIGH, ph);
		write_reg(REG_DEBOUNCE, polls);
		write_reg(REG_DUTY_MAX, dmax);
		cfg_if.valid <= 1'b0;
		settings_used++;
	endtask

	task automatic run_random(input int items);
		int goal, n, pick;
		goal = sent_items + items;
		while (sent_items < goal) begin
			pick = $urandom_range(0, 9);
			if (pick <= 2) begin
				// A press long enough to toggle, sometimes cut short, then a release.
				n = int'(cur_polls) + 1 + $urandom_range(0, 3);
				if ($urandom_range(0, 3) == 0)
					n = $urandom_range(1, n);
				repeat (n) send_poll(0, pick_pot());
				repeat ($urandom_range(1, 3)) send_poll(1, pick_pot());
			end else if (pick <= 6) begin
				repeat ($urandom_range(1, 6)) send_temp(pick_temp());
			end else if (pick <= 8) begin
				repeat ($urandom_range(1, 4)) send_poll(1, pick_pot());
			end else begin
				repeat ($urandom_range(1, 4)) send_item($urandom, $urandom, $urandom, $urandom);
			end
		end
	endtask

	initial begin
		int dir_temps[9] = '{-640, 399, 400, 416, 432, 433, 479, 480, 2000};
		int th[$];
		req_if.valid <= 1'b0;
		req_if.req_type <= REQ_POLL;
		req_if.button_level <= 1'b1;
		req_if.pot_sample <= '0;
		req_if.temperature <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= REG_TEMP_LOW;
		cfg_if.data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Curve points at and around each threshold, then a full toggle into
		// manual mode and back with the default debounce count.
		foreach (dir_temps[i])
			send_temp(dir_temps[i]);
		send_poll(1, POT_MAX);
		send_poll(0, 0);
		send_poll(0, POT_MAX);
		send_poll(0, 2048);
		send_poll(0, 1);
		send_poll(0, POT_MAX);
		send_poll(1, POT_MAX);
		send_poll(1, 0);
		send_temp(500);
		for (int i = 0; i < 5; i++)
			send_poll(0, i * 1000);
		send_poll(1, 1365);
		send_temp(440);

		// The block is in auto mode here, so each of the next twelve samples yields a beat.
		hold_rsp = 1'b1;
		repeat (12) send_temp(pick_temp());
		run_random(PHASE_ITEMS);

		load_regs(-640, -640, 2000, 0, 100, 100, 1, 65535);
		run_random(PHASE_ITEMS);
		load_regs(-100, 300, 1500, 127, 127, 127, 255, 1);
		run_random(PHASE_ITEMS);
		load_regs(1000, 200, 500, 30, 80, 127, 0, 0);
		run_random(PHASE_ITEMS);
		load_regs(-2048, 0, 2047, 100, 0, 100, 2, 40000);
		run_random(PHASE_ITEMS);

		repeat (3) begin
			th = {int'($urandom_range(0, 2640)) - 640, int'($urandom_range(0, 2640)) - 640,
				int'($urandom_range(0, 2640)) - 640};
			if ($urandom_range(0, 3) != 0)
				th.sort();
			load_regs(junk_above(th[0], TEMP_W), junk_above(th[1], TEMP_W),
				junk_above(th[2], TEMP_W), junk_above(rand_pct(), PCT_W),
				junk_above(rand_pct(), PCT_W), junk_above(rand_pct(), PCT_W),
				($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12),
				($urandom_range(0, 2) == 0) ? $urandom_range(1, 100) : $urandom_range(1, 65535));
			run_random(PHASE_ITEMS);
		end

		load_regs(RST_TEMP_LOW, RST_TEMP_MID, RST_TEMP_HIGH, RST_PCT_LOW, RST_PCT_MID,
			RST_PCT_HIGH, RST_DEBOUNCE, RST_DUTY_MAX);
		run_random(PHASE_ITEMS);
		wait_idle();

		$display("Sent %0d request beats (%0d polls, %0d temperature samples) under %0d register settings.",
			sent_items, sent_polls, sent_temps, settings_used);
		$display("Checked %0d duty beats, %0d of them from manual mode; %0d mismatches.",
			results, manual_results, errors);
		if (errors == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
